### rtl/ostp_pkg.sv
// ============================================================================
// ostp_pkg
// Shared types and constants for the one-shot timer pool.
// ============================================================================
`default_nettype none

package ostp_pkg;

  localparam int unsigned DUR_W  = 24;
  localparam int unsigned PER_W  = 10;
  localparam int unsigned REM_W  = 25;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned CNT_W  = 5;

  localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(10);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef struct packed {
    logic [REM_W-1:0] remaining;
    logic             alert;
    logic             notify;
  } slot_entry_t;

  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic              alert_status;
    logic              no_free_slot;
    logic [ID_W-1:0]   slot_id;
  } result_t;

endpackage

`default_nettype wire

### rtl/ostp_slot_ram.sv
// ============================================================================
// ostp_slot_ram
// Slot state memory with one write port, one registered read port and a
// valid bit per entry so that entries read as zero until first written.
// ============================================================================
`default_nettype none

module ostp_slot_ram
  import ostp_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire slot_entry_t   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output slot_entry_t        rdata_o
);

  slot_entry_t            mem [DEPTH];
  logic       [DEPTH-1:0] valid_q;
  slot_entry_t            rdata_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

### rtl/ostp_round_unit.sv
// ============================================================================
// ostp_round_unit
// Rounds a duration up to a multiple of the tick period using a restoring
// remainder computation, one dividend bit per cycle.
// ============================================================================
`default_nettype none

module ostp_round_unit
  import ostp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DUR_W-1:0] dur_i,
  input  wire logic [PER_W-1:0] per_i,
  output logic                  done_o,
  output logic      [REM_W-1:0] rounded_o
);

  logic [DUR_W-1:0] quo_q;
  logic [DUR_W-1:0] dur_q;
  logic [PER_W-1:0] per_q;
  logic [PER_W-1:0] rem_q;
  logic [REM_W-1:0] rounded_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             fix_q;
  logic             done_q;

  logic [PER_W:0]   shifted;
  logic [PER_W:0]   diff;
  logic [PER_W-1:0] rem_step;
  logic [PER_W-1:0] pad;
  logic [REM_W-1:0] round_sum;

  always_comb begin
    shifted   = {rem_q, quo_q[DUR_W-1]};
    diff      = shifted - {1'b0, per_q};
    rem_step  = (shifted >= {1'b0, per_q}) ? diff[PER_W-1:0] : shifted[PER_W-1:0];
    pad       = (rem_q != '0) ? (per_q - rem_q) : '0;
    round_sum = REM_W'(dur_q) + REM_W'(pad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DUR_W - 1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dur_i;
      dur_q <= dur_i;
      per_q <= per_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DUR_W-2:0], 1'b0};
      rem_q <= rem_step;
    end else if (fix_q) begin
      rounded_q <= round_sum;
    end
  end

  assign done_o    = done_q;
  assign rounded_o = rounded_q;

endmodule

`default_nettype wire

### rtl/ostp_ctrl.sv
// ============================================================================
// ostp_ctrl
// Request sequencer: walks the slot memory for ticks and starts, and does
// single-entry accesses for clear and query.
// ============================================================================
`default_nettype none

module ostp_ctrl
  import ostp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned AW         = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire mode_e            mode_i,
  input  wire logic             notify_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [PER_W-1:0] per_i,
  output logic                  round_start_o,
  input  wire logic             round_done_i,
  input  wire logic [REM_W-1:0] rounded_i,
  output logic                  mem_we_o,
  output logic         [AW-1:0] mem_waddr_o,
  output slot_entry_t           mem_wdata_o,
  output logic         [AW-1:0] mem_raddr_o,
  input  wire slot_entry_t      mem_rdata_i,
  output logic                  res_valid_o,
  input  wire logic             res_take_i,
  output result_t               res_o
);

  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_QREAD = 3'd3;
  localparam logic [2:0] ST_QEVAL = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  mode_e            mode_q, mode_d;
  logic             notify_q, notify_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CW-1:0]    raddr_q, raddr_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    paddr_q, paddr_d;
  result_t          res_q, res_d;

  logic             accept;
  logic             idx_in_range;
  logic             issue;
  logic [6:0]       paddr_ext;
  logic [REM_W:0]   diff;
  logic [REM_W-1:0] new_rem;
  logic             below;

  always_comb begin
    accept       = req_valid_i && (state_q == ST_IDLE);
    idx_in_range = ({1'b0, idx_i} < 7'(SLOT_COUNT));
    issue        = (raddr_q < CW'(SLOT_COUNT));
    paddr_ext    = 7'(paddr_q);
    diff         = {1'b0, mem_rdata_i.remaining} - (REM_W + 1)'(per_i);
    new_rem      = (mem_rdata_i.remaining > REM_W'(per_i)) ? diff[REM_W-1:0] : '0;
    below        = (new_rem < REM_W'(per_i));
  end

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    notify_d      = notify_q;
    idx_d         = idx_q;
    raddr_d       = raddr_q;
    pend_d        = pend_q;
    paddr_d       = paddr_q;
    res_d         = res_q;
    round_start_o = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = paddr_q;
    mem_wdata_o   = '0;
    mem_raddr_o   = raddr_q[AW-1:0];
    res_valid_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d   = mode_i;
          notify_d = notify_i;
          idx_d    = idx_i;
          raddr_d  = '0;
          pend_d   = 1'b0;
          res_d    = '0;
          case (mode_i)
            MODE_TICK: begin
              state_d = ST_WALK;
            end
            MODE_START: begin
              round_start_o      = 1'b1;
              res_d.no_free_slot = 1'b1;
              state_d            = ST_ROUND;
            end
            MODE_CLEAR: begin
              if (idx_in_range) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = idx_i[AW-1:0];
              end
              state_d = ST_DONE;
            end
            MODE_QUERY: begin
              state_d = idx_in_range ? ST_QREAD : ST_DONE;
            end
          endcase
        end
      end
      ST_ROUND: begin
        if (round_done_i) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        pend_d  = issue;
        paddr_d = raddr_q[AW-1:0];
        if (issue) begin
          raddr_d = raddr_q + CW'(1);
        end
        if (!issue && !pend_q) begin
          state_d = ST_DONE;
        end
        if (pend_q) begin
          if (mode_q == MODE_START) begin
            if (mem_rdata_i.remaining == '0) begin
              mem_we_o                = 1'b1;
              mem_wdata_o.remaining   = rounded_i;
              mem_wdata_o.notify      = notify_q;
              res_d.slot_id           = paddr_ext[ID_W-1:0];
              res_d.no_free_slot      = 1'b0;
              state_d                 = ST_DONE;
            end
          end else if (mem_rdata_i.remaining != '0) begin
            mem_we_o              = 1'b1;
            mem_wdata_o.remaining = new_rem;
            mem_wdata_o.alert     = mem_rdata_i.alert | below;
            mem_wdata_o.notify    = mem_rdata_i.notify;
            if (below && mem_rdata_i.notify && (paddr_ext < 7'(MASK_W))) begin
              res_d.expired_mask[paddr_ext[ID_W-1:0]] = 1'b1;
            end
          end
        end
      end
      ST_QREAD: begin
        mem_raddr_o = idx_q[AW-1:0];
        state_d     = ST_QEVAL;
      end
      ST_QEVAL: begin
        res_d.alert_status = (mem_rdata_i.remaining == '0) && mem_rdata_i.alert;
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      raddr_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      raddr_q <= raddr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    notify_q <= notify_d;
    idx_q    <= idx_d;
    paddr_q  <= paddr_d;
    res_q    <= res_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/one_shot_timer_pool.sv
// ============================================================================
// one_shot_timer_pool
// Pool of one-shot timer slots held in a synchronous memory, with tick,
// start, clear and query requests and one result per request.
// ============================================================================
//
// Channel    Direction  Handshake                      Content
// s_axis     in         s_axis_tvalid / s_axis_tready  request (mode in tuser)
// m_axis     out        m_axis_tvalid / m_axis_tready  result of each request
// cfg        in         cfg_valid_i / cfg_ready_o      tick period in ms
//
// A tick walks the slot memory one entry per cycle, bound by its single read
// port. A start runs the rounding unit over the duration one bit at a time,
// adds the pad, and then walks the slot memory up to the first free slot.
// Reset clears the per-entry valid bits at once, so no clearing pass is run.
// A new request is taken while the previous result waits in the output
// register; a finished request holds until that register is free.
`default_nettype none

module one_shot_timer_pool
  import ostp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [23:0] duration_ms, [24] notify_wanted, [30:25] slot_index, [31] zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] slot_id, [4] no_free_slot, [5] alert_status, [21:6] expired_mask,
  // [23:22] zero
  output logic      [23:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [PER_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [PER_W-1:0] period_q;
  logic [PER_W-1:0] per_eff;
  logic             round_start;
  logic             round_done;
  logic [REM_W-1:0] rounded;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  slot_entry_t      mem_wdata;
  logic [AW-1:0]    mem_raddr;
  slot_entry_t      mem_rdata;
  logic             res_valid;
  logic             res_take;
  result_t          res;
  logic             m_valid_q;
  result_t          m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign per_eff     = (period_q == '0) ? PER_W'(1) : period_q;

  ostp_round_unit u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (round_start),
    .dur_i     (s_axis_tdata[DUR_W-1:0]),
    .per_i     (per_eff),
    .done_o    (round_done),
    .rounded_o (rounded)
  );

  ostp_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ostp_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .mode_i        (mode_e'(s_axis_tuser)),
    .notify_i      (s_axis_tdata[DUR_W]),
    .idx_i         (s_axis_tdata[DUR_W+IDX_W:DUR_W+1]),
    .per_i         (per_eff),
    .round_start_o (round_start),
    .round_done_i  (round_done),
    .rounded_i     (rounded),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_o         (res)
  );

  assign res_take = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_take) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_data_q};

endmodule

`default_nettype wire

### sim/timer_pool_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// timer_pool_checker
// Watches the request, result and period channels of the timer pool, keeps
// its own copy of the slot table and compares every result with the answer
// that table gives, oldest first.
// ============================================================================

module timer_pool_checker
  import ostp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,
  input  logic [1:0]         s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [23:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [PER_W-1:0]   cfg_data_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  logic [REM_W-1:0] remaining [SLOT_COUNT];
  logic             alert     [SLOT_COUNT];
  logic             notify_en [SLOT_COUNT];
  logic [PER_W-1:0] period;
  result_t          owed_answers [$];
  result_t          got;
  result_t          want;
  int unsigned      mismatches;

  function automatic logic [REM_W-1:0] step_size();
    return (period == '0) ? REM_W'(1) : REM_W'(period);
  endfunction

  function automatic result_t serve_request(mode_e mode, logic [DUR_W-1:0] dur,
                                            logic notify, logic [IDX_W-1:0] idx);
    result_t          res;
    logic [REM_W-1:0] per;
    logic [REM_W-1:0] len;
    logic [REM_W-1:0] rest;
    bit               found;
    res   = '0;
    per   = step_size();
    found = 1'b0;
    case (mode)
      MODE_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (remaining[i] != '0) begin
            remaining[i] = (remaining[i] > per) ? remaining[i] - per : '0;
            if (remaining[i] < per) begin
              alert[i] = 1'b1;
              if (notify_en[i] && i < MASK_W) begin
                res.expired_mask[i] = 1'b1;
              end
            end
          end
        end
      end
      MODE_START: begin
        len  = REM_W'(dur);
        rest = len % per;
        if (rest != '0) begin
          len = len + per - rest;
        end
        res.no_free_slot = 1'b1;
        for (int i = 0; i < SLOT_COUNT && !found; i++) begin
          if (remaining[i] == '0) begin
            remaining[i]     = len;
            alert[i]         = 1'b0;
            notify_en[i]     = notify;
            res.slot_id      = ID_W'(i);
            res.no_free_slot = 1'b0;
            found            = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        if (idx < SLOT_COUNT) begin
          remaining[idx] = '0;
          alert[idx]     = 1'b0;
          notify_en[idx] = 1'b0;
        end
      end
      default: begin
        if (idx < SLOT_COUNT) begin
          if (remaining[idx] == '0) begin
            res.alert_status = alert[idx];
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string label, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, label, expected, actual);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        remaining[i] = '0;
        alert[i]     = 1'b0;
        notify_en[i] = 1'b0;
      end
      period     = PERIOD_RESET;
      mismatches = 0;
      owed_answers.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        period = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_answers.push_back(serve_request(mode_e'(s_axis_tuser), s_axis_tdata[23:0],
                                             s_axis_tdata[24], s_axis_tdata[30:25]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (owed_answers.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, actual %h", $time, m_axis_tdata);
        end else begin
          want = owed_answers.pop_front();
          check_field("slot_id", 32'(want.slot_id), 32'(got.slot_id));
          check_field("no_free_slot", 32'(want.no_free_slot), 32'(got.no_free_slot));
          check_field("alert_status", 32'(want.alert_status), 32'(got.alert_status));
          check_field("expired_mask", 32'(want.expired_mask), 32'(got.expired_mask));
        end
      end
      errors_o  <= mismatches;
      pending_o <= owed_answers.size();
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives the timer pool with a short directed sequence and then with random
// tick, start, clear and query requests under several tick periods, with
// random gaps on both streams, and reports the checker's verdict.
// ============================================================================

module tb_top;
  import ostp_pkg::*;

  localparam int unsigned SLOT_COUNT   = 16;
  localparam int unsigned RUN_LIMIT    = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned PHASES       = 7;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata  = '0;
  logic [1:0]       s_axis_tuser  = MODE_TICK;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [PER_W-1:0] cfg_data_i    = '0;

  int unsigned      errors;
  int unsigned      pending;
  int unsigned      cycles        = 0;
  int unsigned      sent          = 0;
  int unsigned      stall_left    = 0;
  logic [PER_W-1:0] period_now    = PERIOD_RESET;
  bit               sender_calm   = 1'b0;
  bit               receiver_calm = 1'b0;

  always #2 clk_i = ~clk_i;

  one_shot_timer_pool #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  timer_pool_checker #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!receiver_calm && $urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(mode_e mode, logic [DUR_W-1:0] dur, logic notify,
                              logic [IDX_W-1:0] idx);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sender_calm || roll < 65) begin
      gap = 0;
    end else if (roll < 95) begin
      gap = $urandom_range(1, 4);
    end else begin
      gap = $urandom_range(10, 60);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {1'b0, idx, notify, dur};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_period(logic [PER_W-1:0] value);
    drain();
    repeat (SLOT_COUNT + 3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period_now = value;
  endtask

  task automatic random_request();
    int unsigned      roll;
    int unsigned      span;
    logic [DUR_W-1:0] dur;
    logic [IDX_W-1:0] idx;
    mode_e            mode;
    span = (period_now == '0) ? 1 : int'(period_now);
    roll = $urandom_range(0, 99);
    if (roll < 36) begin
      mode = MODE_TICK;
    end else if (roll < 66) begin
      mode = MODE_START;
    end else if (roll < 80) begin
      mode = MODE_CLEAR;
    end else begin
      mode = MODE_QUERY;
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      dur = DUR_W'($urandom_range(0, 6 * span));
    end else if (roll < 90) begin
      dur = DUR_W'($urandom_range(0, 2));
    end else begin
      dur = DUR_W'($urandom());
    end
    idx = ($urandom_range(0, 9) < 8) ? IDX_W'($urandom_range(0, SLOT_COUNT - 1))
                                     : IDX_W'($urandom());
    send_request(mode, dur, 1'($urandom()), idx);
  endtask

  initial begin
    logic [PER_W-1:0] periods [PHASES];
    int unsigned      target;
    periods = '{10'd1, 10'd1000, 10'd0, 10'd1023, PER_W'($urandom_range(1, 1000)),
                10'd3, PER_W'($urandom_range(0, 1023))};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(MODE_QUERY, 24'd0, 1'b0, 6'd0);
    send_request(MODE_START, 24'd0, 1'b1, 6'd0);
    send_request(MODE_START, 24'd1, 1'b1, 6'd0);
    send_request(MODE_START, 24'd15, 1'b0, 6'd0);
    send_request(MODE_START, 24'hFFFFFF, 1'b1, 6'd63);
    send_request(MODE_TICK, 24'hFFFFFF, 1'b1, 6'd63);
    send_request(MODE_QUERY, 24'd0, 1'b0, 6'd0);
    send_request(MODE_QUERY, 24'd0, 1'b0, 6'd1);
    send_request(MODE_TICK, 24'd0, 1'b0, 6'd0);
    send_request(MODE_QUERY, 24'd0, 1'b0, 6'd1);
    send_request(MODE_CLEAR, 24'd0, 1'b0, 6'd0);
    send_request(MODE_QUERY, 24'd0, 1'b0, 6'd0);
    send_request(MODE_CLEAR, 24'd0, 1'b0, 6'd63);
    send_request(MODE_QUERY, 24'd0, 1'b0, 6'd45);
    repeat (SLOT_COUNT) send_request(MODE_START, 24'd1000000, 1'b1, 6'd0);

    for (int p = 0; p < PHASES; p++) begin
      write_period(periods[p]);
      sender_calm   <= ($urandom_range(0, 3) == 0);
      receiver_calm <= ($urandom_range(0, 3) == 0);
      target = sent + RANDOM_ITEMS / PHASES;
      while (sent < target) begin
        if ($urandom_range(0, 49) == 0) begin
          repeat (SLOT_COUNT + 1) begin
            send_request(MODE_START, DUR_W'($urandom_range(0, 4000)), 1'($urandom()),
                         IDX_W'($urandom()));
          end
        end else begin
          random_request();
        end
      end
    end

    drain();
    repeat (3 * SLOT_COUNT + 30) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### one_shot_timer_pool.f
rtl/ostp_pkg.sv
rtl/ostp_slot_ram.sv
rtl/ostp_round_unit.sv
rtl/ostp_ctrl.sv
rtl/one_shot_timer_pool.sv
sim/timer_pool_checker.sv
sim/tb_top.sv
